// ===== sv/cpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_pkg
// Types, opcodes and record codes shared by the command packet decoder.
// ----------------------------------------------------------------------------
package cpd_pkg;

    // stream offset counter width (wraps at this many bits)
    localparam int OFFSET_BITS = 24;
    localparam int SRC_OFF_W   = 24;

    // record queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // header word
    localparam logic [1:0]  PKT_TYPE2 = 2'b10;
    localparam logic [1:0]  PKT_TYPE3 = 2'b11;
    localparam logic [31:0] TYPE2_NOP = 32'h8000_0000;

    // type-3 opcodes
    localparam logic [7:0] OP_INDEX_BASE    = 8'h26;
    localparam logic [7:0] OP_DRAW_INDEX    = 8'h2B;
    localparam logic [7:0] OP_DRAW_AUTO     = 8'h2D;
    localparam logic [7:0] OP_WRITE_DATA    = 8'h37;
    localparam logic [7:0] OP_WAIT          = 8'h3C;
    localparam logic [7:0] OP_EVENT         = 8'h46;
    localparam logic [7:0] OP_RELEASE       = 8'h49;
    localparam logic [7:0] OP_SET_CONTEXT   = 8'h69;
    localparam logic [7:0] OP_SET_SH        = 8'h76;
    localparam logic [7:0] OP_SET_UCONFIG   = 8'h79;

    typedef enum logic [2:0] {
        KIND_REG_VALUE  = 3'd0,
        KIND_DRAW       = 3'd1,
        KIND_WRITE_HDR  = 3'd2,
        KIND_WRITE_DATA = 3'd3,
        KIND_SYNC       = 3'd4,
        KIND_ERROR      = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_BAD_TYPE   = 3'd0,
        ERR_BAD_TYPE2  = 3'd1,
        ERR_TRUNCATED  = 3'd2,
        ERR_UNKNOWN_OP = 3'd3,
        ERR_SHORT      = 3'd4
    } err_code_t;

    // register class / sync kind share the sub_kind field
    localparam logic [1:0] SUB_CONTEXT = 2'd0;
    localparam logic [1:0] SUB_SH      = 2'd1;
    localparam logic [1:0] SUB_UCONFIG = 2'd2;
    localparam logic [1:0] SUB_WAIT    = 2'd0;
    localparam logic [1:0] SUB_EVENT   = 2'd1;
    localparam logic [1:0] SUB_RELEASE = 2'd2;

    typedef struct packed {
        logic [31:0] word;
        logic        end_of_stream;
    } cmd_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [7:0]           opcode;
        logic [SRC_OFF_W-1:0] source_offset;
        logic [1:0]           sub_kind;
        logic [13:0]          word_index;
        logic [31:0]          value;
        logic [31:0]          lead_word;
        logic [31:0]          count_word;
        logic [63:0]          address;
        logic                 indexed;
        logic [2:0]           error_code;
        logic                 last_of_packet;
    } rec_t;

    // records produced by one word, first in rec_a
    typedef struct packed {
        logic [1:0] cnt;
        rec_t       rec_a;
        rec_t       rec_b;
    } push_t;

endpackage
`default_nettype wire

// ===== sv/command_packet_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// command_packet_decoder_top
// Command stream packet decoder: one 32-bit word in, zero to two records out.
// Records enter the record queue and are offered on rec in arrival order.
// Throughput: one word per cycle; the rec port drains one record per cycle,
// and cmd_ready drops while the 4-entry record queue has fewer than 2 free.
// Reset: packet state, stream offset and queue cleared; type-2 filler skip off.
// ----------------------------------------------------------------------------
module command_packet_decoder_top
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic          cfg_wr_data,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire cpd_pkg::cmd_t cmd,
    output logic               rec_valid,
    input  wire logic          rec_ready,
    output cpd_pkg::rec_t      rec
);

    cpd_pkg::push_t push;
    logic           take;

    assign take = cmd_valid && cmd_ready;

    cpd_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .take        (take),
        .cmd         (cmd),
        .push        (push)
    );

    cpd_rec_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (cmd_ready),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

endmodule
`default_nettype wire

// ===== sv/cpd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_decode
// Packet state and per-word decode; emits up to two records per word.
// ----------------------------------------------------------------------------
module cpd_decode
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic          cfg_wr_data,
    input  wire logic          take,
    input  wire cpd_pkg::cmd_t cmd,
    output cpd_pkg::push_t     push
);

    logic                             allow_nop_reg;
    logic                             in_payload_reg, in_payload_next;
    logic                             err_latched_reg, err_latched_next;
    logic [7:0]                       opcode_reg, opcode_next;
    logic [14:0]                      length_reg, length_next;
    logic [14:0]                      position_reg, position_next;
    logic [cpd_pkg::OFFSET_BITS-1:0]  hdr_off_reg, hdr_off_next;
    logic [cpd_pkg::OFFSET_BITS-1:0]  stream_pos_reg, stream_pos_next;
    logic [31:0]                      lead_reg, lead_next;
    logic [31:0]                      count_reg, count_next;
    logic [63:0]                      addr_reg, addr_next;

    always_comb
    begin
        cpd_pkg::rec_t pay;
        cpd_pkg::rec_t err;
        logic          pay_v;
        logic          err_v;
        logic [31:0]   w;
        logic [14:0]   pos;
        logic [14:0]   pos_inc;
        logic          last;
        logic [14:0]   need;

        w       = cmd.word;
        pos     = position_reg;
        pos_inc = position_reg + 15'd1;
        last    = (pos_inc == length_reg);
        need    = 15'd2;
        pay     = '0;
        err     = '0;
        pay_v   = 1'b0;
        err_v   = 1'b0;

        in_payload_next  = in_payload_reg;
        err_latched_next = err_latched_reg;
        opcode_next      = opcode_reg;
        length_next      = length_reg;
        position_next    = position_reg;
        hdr_off_next     = hdr_off_reg;
        lead_next        = lead_reg;
        count_next       = count_reg;
        addr_next        = addr_reg;

        err.kind = cpd_pkg::KIND_ERROR;

        if (!err_latched_reg)
        begin
            if (!in_payload_reg)
            begin
                if (w[31:30] == cpd_pkg::PKT_TYPE2)
                begin
                    if (!(allow_nop_reg && w == cpd_pkg::TYPE2_NOP))
                    begin
                        err_v          = 1'b1;
                        err.error_code = cpd_pkg::ERR_BAD_TYPE2;
                        err.source_offset = cpd_pkg::SRC_OFF_W'(stream_pos_reg);
                    end
                end
                else if (w[31:30] != cpd_pkg::PKT_TYPE3)
                begin
                    err_v          = 1'b1;
                    err.error_code = cpd_pkg::ERR_BAD_TYPE;
                    err.source_offset = cpd_pkg::SRC_OFF_W'(stream_pos_reg);
                end
                else
                begin
                    opcode_next     = w[15:8];
                    length_next     = {1'b0, w[29:16]} + 15'd1;
                    position_next   = '0;
                    hdr_off_next    = stream_pos_reg;
                    lead_next       = '0;
                    count_next      = '0;
                    addr_next       = '0;
                    in_payload_next = 1'b1;
                end
            end
            else
            begin
                // common header of any record for this packet
                pay.opcode        = opcode_reg;
                pay.source_offset = cpd_pkg::SRC_OFF_W'(hdr_off_reg);
                err.opcode        = opcode_reg;
                err.source_offset = cpd_pkg::SRC_OFF_W'(hdr_off_reg);
                err.error_code    = cpd_pkg::ERR_SHORT;

                if (opcode_reg inside {cpd_pkg::OP_SET_CONTEXT, cpd_pkg::OP_SET_SH,
                                       cpd_pkg::OP_SET_UCONFIG})
                begin
                    if (pos == '0)
                        lead_next = w;
                    else
                    begin
                        pay_v              = 1'b1;
                        pay.kind           = cpd_pkg::KIND_REG_VALUE;
                        pay.sub_kind       = (opcode_reg == cpd_pkg::OP_SET_CONTEXT) ?
                                             cpd_pkg::SUB_CONTEXT :
                                             (opcode_reg == cpd_pkg::OP_SET_SH) ?
                                             cpd_pkg::SUB_SH : cpd_pkg::SUB_UCONFIG;
                        pay.word_index     = 14'(pos - 15'd1);
                        pay.value          = w;
                        pay.lead_word      = lead_reg;
                        pay.last_of_packet = last;
                    end
                    err_v = last && (length_reg < 15'd2);
                end
                else if (opcode_reg inside {cpd_pkg::OP_WAIT, cpd_pkg::OP_EVENT,
                                            cpd_pkg::OP_RELEASE})
                begin
                    pay_v              = 1'b1;
                    pay.kind           = cpd_pkg::KIND_SYNC;
                    pay.sub_kind       = (opcode_reg == cpd_pkg::OP_WAIT) ?
                                         cpd_pkg::SUB_WAIT :
                                         (opcode_reg == cpd_pkg::OP_EVENT) ?
                                         cpd_pkg::SUB_EVENT : cpd_pkg::SUB_RELEASE;
                    pay.word_index     = pos[13:0];
                    pay.value          = w;
                    pay.last_of_packet = last;
                end
                else if (opcode_reg == cpd_pkg::OP_WRITE_DATA)
                begin
                    if (pos == 15'd0)
                        lead_next = w;
                    else if (pos == 15'd1)
                        addr_next[31:0] = w;
                    else if (pos == 15'd2)
                    begin
                        addr_next[63:32] = w;
                        pay_v            = (length_reg >= 15'd4);
                        pay.kind         = cpd_pkg::KIND_WRITE_HDR;
                        pay.lead_word    = lead_reg;
                        pay.address      = {w, addr_reg[31:0]};
                    end
                    else
                    begin
                        pay_v              = 1'b1;
                        pay.kind           = cpd_pkg::KIND_WRITE_DATA;
                        pay.word_index     = 14'(pos - 15'd3);
                        pay.value          = w;
                        pay.lead_word      = lead_reg;
                        pay.address        = addr_reg;
                        pay.last_of_packet = last;
                    end
                    err_v = last && (length_reg < 15'd4);
                end
                else if (opcode_reg inside {cpd_pkg::OP_INDEX_BASE, cpd_pkg::OP_DRAW_INDEX,
                                            cpd_pkg::OP_DRAW_AUTO})
                begin
                    if (opcode_reg == cpd_pkg::OP_DRAW_INDEX)
                        need = 15'd4;
                    if (opcode_reg == cpd_pkg::OP_INDEX_BASE)
                    begin
                        if (pos == 15'd0)
                            addr_next[31:0] = w;
                        else if (pos == 15'd1)
                            addr_next[63:32] = w;
                    end
                    else if (opcode_reg == cpd_pkg::OP_DRAW_AUTO)
                    begin
                        if (pos == 15'd0)
                            count_next = w;
                        else if (pos == 15'd1)
                            lead_next = w;
                    end
                    else
                    begin
                        if (pos == 15'd0)
                            count_next = w;
                        else if (pos == 15'd1)
                            addr_next[31:0] = w;
                        else if (pos == 15'd2)
                            addr_next[63:32] = w;
                        else if (pos == 15'd3)
                            lead_next = w;
                    end
                    if (last)
                    begin
                        if (length_reg < need)
                            err_v = 1'b1;
                        else
                        begin
                            pay_v              = 1'b1;
                            pay.kind           = cpd_pkg::KIND_DRAW;
                            pay.lead_word      = lead_next;
                            pay.count_word     = count_next;
                            pay.address        = addr_next;
                            pay.indexed        = (opcode_reg != cpd_pkg::OP_DRAW_AUTO);
                            pay.last_of_packet = 1'b1;
                        end
                    end
                end
                else
                begin
                    err_v          = last;
                    err.error_code = cpd_pkg::ERR_UNKNOWN_OP;
                end

                position_next = pos_inc;
                if (last)
                    in_payload_next = 1'b0;
            end

            if (err_v)
            begin
                err_latched_next = 1'b1;
                in_payload_next  = 1'b0;
            end
            else if (cmd.end_of_stream && in_payload_next)
            begin
                // stream ended inside a packet, header word included
                err_v             = 1'b1;
                err.opcode        = opcode_next;
                err.source_offset = cpd_pkg::SRC_OFF_W'(hdr_off_next);
                err.error_code    = cpd_pkg::ERR_TRUNCATED;
            end
        end

        stream_pos_next = stream_pos_reg + cpd_pkg::OFFSET_BITS'(1);
        if (cmd.end_of_stream)
        begin
            in_payload_next  = 1'b0;
            err_latched_next = 1'b0;
            stream_pos_next  = '0;
        end

        // compact: payload record first, error after it
        push.rec_a = pay_v ? pay : err;
        push.rec_b = err;
        push.cnt   = take ? (2'(pay_v) + 2'(err_v)) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_nop_reg   <= 1'b0;
            in_payload_reg  <= 1'b0;
            err_latched_reg <= 1'b0;
            opcode_reg      <= '0;
            length_reg      <= '0;
            position_reg    <= '0;
            hdr_off_reg     <= '0;
            stream_pos_reg  <= '0;
            lead_reg        <= '0;
            count_reg       <= '0;
            addr_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                allow_nop_reg <= cfg_wr_data;
            if (take)
            begin
                in_payload_reg  <= in_payload_next;
                err_latched_reg <= err_latched_next;
                opcode_reg      <= opcode_next;
                length_reg      <= length_next;
                position_reg    <= position_next;
                hdr_off_reg     <= hdr_off_next;
                stream_pos_reg  <= stream_pos_next;
                lead_reg        <= lead_next;
                count_reg       <= count_next;
                addr_reg        <= addr_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/cpd_rec_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_rec_fifo
// Small record queue: up to two records in per cycle, one out.
// ----------------------------------------------------------------------------
module cpd_rec_fifo
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cpd_pkg::push_t push,
    output logic                room,
    output logic                rec_valid,
    input  wire logic           rec_ready,
    output cpd_pkg::rec_t       rec
);

    cpd_pkg::rec_t                 mem [cpd_pkg::FIFO_DEPTH];
    logic [cpd_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [cpd_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [cpd_pkg::FIFO_CW-1:0]   count_reg, count_next;
    logic [cpd_pkg::FIFO_AW-1:0]   wr_ptr_b;
    logic                          pop;

    assign rec_valid = (count_reg != '0);
    assign rec       = mem[rd_ptr_reg];
    assign pop       = rec_valid && rec_ready;
    // a word may produce two records
    assign room      = (count_reg <= cpd_pkg::FIFO_CW'(cpd_pkg::FIFO_DEPTH - 2));

    assign wr_ptr_b    = wr_ptr_reg + cpd_pkg::FIFO_AW'(1);
    assign wr_ptr_next = wr_ptr_reg + cpd_pkg::FIFO_AW'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + cpd_pkg::FIFO_AW'(pop);
    assign count_next  = count_reg + cpd_pkg::FIFO_CW'(push.cnt) - cpd_pkg::FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_ptr_reg] <= push.rec_a;
        if (push.cnt == 2'd2)
            mem[wr_ptr_b] <= push.rec_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== verif/tb_command_packet_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_command_packet_decoder_top
// Self-checking bench for the command packet decoder. Command words are
// pushed through the valid/ready port. A scoreboard decodes each accepted
// word the same way the block should and queues the records it must emit.
// Every record taken from the rec port is compared field by field with the
// oldest queued one. Directed streams come first, then four random phases,
// each with its own idle and stall mix, alternating the type-2 filler setting.
// ----------------------------------------------------------------------------
module tb_command_packet_decoder_top;

    class packet_scoreboard;
        cpd_pkg::rec_t pending_records[$];
        int            failures;
        int            live_words;
        logic          allow_nop;
        logic          in_packet;
        logic          halted;
        logic [7:0]    pkt_op;
        logic [14:0]   pay_len;
        logic [14:0]   pay_pos;
        logic [23:0]   hdr_off;
        logic [23:0]   stream_pos;
        logic [31:0]   held_lead;
        logic [31:0]   held_count;
        logic [63:0]   held_addr;

        function new();
            failures   = 0;
            live_words = 0;
            allow_nop  = 1'b0;
            in_packet  = 1'b0;
            halted     = 1'b0;
            pkt_op     = '0;
            pay_len    = '0;
            pay_pos    = '0;
            hdr_off    = '0;
            stream_pos = '0;
            held_lead  = '0;
            held_count = '0;
            held_addr  = '0;
        endfunction

        function string show(cpd_pkg::rec_t r);
            return $sformatf({"kind=%0d op=%h off=%h sub=%0d idx=%0d val=%h lead=%h",
                              " cnt=%h addr=%h ix=%0d err=%0d last=%0d"},
                             r.kind, r.opcode, r.source_offset, r.sub_kind, r.word_index,
                             r.value, r.lead_word, r.count_word, r.address, r.indexed,
                             r.error_code, r.last_of_packet);
        endfunction

        function cpd_pkg::rec_t blank(cpd_pkg::kind_t k);
            cpd_pkg::rec_t r;
            r = '0;
            r.kind          = k;
            r.opcode        = pkt_op;
            r.source_offset = hdr_off;
            return r;
        endfunction

        function void flag_error(cpd_pkg::err_code_t code, logic [7:0] op,
                                 logic [23:0] where);
            cpd_pkg::rec_t r;
            r = '0;
            r.kind          = cpd_pkg::KIND_ERROR;
            r.opcode        = op;
            r.source_offset = where;
            r.error_code    = code;
            pending_records.push_back(r);
            halted    = 1'b1;
            in_packet = 1'b0;
        endfunction

        function void payload_word(logic [31:0] w);
            cpd_pkg::rec_t r;
            logic [14:0]   pos;
            logic          last;
            int            need;
            pos  = pay_pos;
            last = (pos + 15'd1) == pay_len;
            case (pkt_op)
                cpd_pkg::OP_SET_CONTEXT, cpd_pkg::OP_SET_SH, cpd_pkg::OP_SET_UCONFIG:
                begin
                    if (pos == 0)
                    begin
                        held_lead = w;
                    end
                    else
                    begin
                        r = blank(cpd_pkg::KIND_REG_VALUE);
                        r.sub_kind = (pkt_op == cpd_pkg::OP_SET_CONTEXT) ?
                                     cpd_pkg::SUB_CONTEXT :
                                     (pkt_op == cpd_pkg::OP_SET_SH) ?
                                     cpd_pkg::SUB_SH : cpd_pkg::SUB_UCONFIG;
                        r.word_index     = 14'(pos - 15'd1);
                        r.value          = w;
                        r.lead_word      = held_lead;
                        r.last_of_packet = last;
                        pending_records.push_back(r);
                    end
                    if (last && pay_len < 2)
                        flag_error(cpd_pkg::ERR_SHORT, pkt_op, hdr_off);
                end
                cpd_pkg::OP_WAIT, cpd_pkg::OP_EVENT, cpd_pkg::OP_RELEASE:
                begin
                    r = blank(cpd_pkg::KIND_SYNC);
                    r.sub_kind = (pkt_op == cpd_pkg::OP_WAIT) ? cpd_pkg::SUB_WAIT :
                                 (pkt_op == cpd_pkg::OP_EVENT) ? cpd_pkg::SUB_EVENT :
                                 cpd_pkg::SUB_RELEASE;
                    r.word_index     = 14'(pos);
                    r.value          = w;
                    r.last_of_packet = last;
                    pending_records.push_back(r);
                end
                cpd_pkg::OP_WRITE_DATA:
                begin
                    if (pos == 0)
                    begin
                        held_lead = w;
                    end
                    else if (pos == 1)
                    begin
                        held_addr[31:0] = w;
                    end
                    else if (pos == 2)
                    begin
                        held_addr[63:32] = w;
                        // header record only when at least one data word follows
                        if (pay_len >= 4)
                        begin
                            r = blank(cpd_pkg::KIND_WRITE_HDR);
                            r.lead_word = held_lead;
                            r.address   = held_addr;
                            pending_records.push_back(r);
                        end
                    end
                    else
                    begin
                        r = blank(cpd_pkg::KIND_WRITE_DATA);
                        r.word_index     = 14'(pos - 15'd3);
                        r.value          = w;
                        r.lead_word      = held_lead;
                        r.address        = held_addr;
                        r.last_of_packet = last;
                        pending_records.push_back(r);
                    end
                    if (last && pay_len < 4)
                        flag_error(cpd_pkg::ERR_SHORT, pkt_op, hdr_off);
                end
                cpd_pkg::OP_INDEX_BASE, cpd_pkg::OP_DRAW_INDEX, cpd_pkg::OP_DRAW_AUTO:
                begin
                    need = (pkt_op == cpd_pkg::OP_DRAW_INDEX) ? 4 : 2;
                    if (pkt_op == cpd_pkg::OP_INDEX_BASE)
                    begin
                        if (pos == 0)
                            held_addr[31:0] = w;
                        else if (pos == 1)
                            held_addr[63:32] = w;
                    end
                    else if (pkt_op == cpd_pkg::OP_DRAW_AUTO)
                    begin
                        if (pos == 0)
                            held_count = w;
                        else if (pos == 1)
                            held_lead = w;
                    end
                    else
                    begin
                        if (pos == 0)
                            held_count = w;
                        else if (pos == 1)
                            held_addr[31:0] = w;
                        else if (pos == 2)
                            held_addr[63:32] = w;
                        else if (pos == 3)
                            held_lead = w;
                    end
                    // words past the used ones are dropped without a record
                    if (last)
                    begin
                        if (pay_len < need)
                        begin
                            flag_error(cpd_pkg::ERR_SHORT, pkt_op, hdr_off);
                        end
                        else
                        begin
                            r = blank(cpd_pkg::KIND_DRAW);
                            r.lead_word      = held_lead;
                            r.count_word     = held_count;
                            r.address        = held_addr;
                            r.indexed        = (pkt_op != cpd_pkg::OP_DRAW_AUTO);
                            r.last_of_packet = 1'b1;
                            pending_records.push_back(r);
                        end
                    end
                end
                default:
                begin
                    if (last)
                        flag_error(cpd_pkg::ERR_UNKNOWN_OP, pkt_op, hdr_off);
                end
            endcase
            pay_pos = pos + 15'd1;
            if (last)
                in_packet = 1'b0;
        endfunction

        // called once per accepted command request
        function void decode_word(cpd_pkg::cmd_t c);
            logic [23:0] here;
            here = stream_pos;
            live_words++;
            if (!halted)
            begin
                if (!in_packet)
                begin
                    if (c.word[31:30] == cpd_pkg::PKT_TYPE2)
                    begin
                        if (!(allow_nop && c.word == cpd_pkg::TYPE2_NOP))
                            flag_error(cpd_pkg::ERR_BAD_TYPE2, 8'h00, here);
                    end
                    else if (c.word[31:30] != cpd_pkg::PKT_TYPE3)
                    begin
                        flag_error(cpd_pkg::ERR_BAD_TYPE, 8'h00, here);
                    end
                    else
                    begin
                        pkt_op     = c.word[15:8];
                        pay_len    = 15'(c.word[29:16]) + 15'd1;
                        pay_pos    = '0;
                        hdr_off    = here;
                        held_lead  = '0;
                        held_count = '0;
                        held_addr  = '0;
                        in_packet  = 1'b1;
                    end
                end
                else
                begin
                    payload_word(c.word);
                end
                // truncation lands after any record this word produced
                if (c.end_of_stream && in_packet && !halted)
                    flag_error(cpd_pkg::ERR_TRUNCATED, pkt_op, hdr_off);
            end
            stream_pos = stream_pos + 24'd1;
            if (c.end_of_stream)
            begin
                in_packet  = 1'b0;
                halted     = 1'b0;
                stream_pos = '0;
            end
        endfunction

        function void check_record(cpd_pkg::rec_t r);
            cpd_pkg::rec_t e;
            if (pending_records.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected record: %s", show(r));
                return;
            end
            e = pending_records.pop_front();
            if (r.kind !== e.kind || r.opcode !== e.opcode ||
                r.source_offset !== e.source_offset || r.sub_kind !== e.sub_kind ||
                r.word_index !== e.word_index || r.value !== e.value ||
                r.lead_word !== e.lead_word || r.count_word !== e.count_word ||
                r.address !== e.address || r.indexed !== e.indexed ||
                r.error_code !== e.error_code || r.last_of_packet !== e.last_of_packet)
            begin
                failures++;
                if (failures <= 10)
                    $display("record mismatch\n  expected %s\n  actual   %s",
                             show(e), show(r));
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_wr_en;
    logic          cfg_wr_data;
    logic          cmd_valid;
    logic          cmd_ready;
    cpd_pkg::cmd_t cmd;
    logic          rec_valid;
    logic          rec_ready;
    cpd_pkg::rec_t rec;

    int send_idle_pct;
    int recv_stall_pct;

    packet_scoreboard sb;

    command_packet_decoder_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec         (rec)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        rec_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rec_valid && rec_ready)
            sb.check_record(rec);
    end

    // entered and left at a falling edge; valid stays high on return
    task automatic send_word(input logic [31:0] w, input logic eos);
        cpd_pkg::cmd_t req;
        req.word          = w;
        req.end_of_stream = eos;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd       = req;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sb.decode_word(req);
        @(negedge clk);
    endtask

    // header with count cnt, then the first 'sent' payload words;
    // eos goes on the last word sent
    task automatic send_packet(input logic [7:0] op, input int cnt, input int sent,
                               input logic eos);
        logic [13:0] cnt_field;
        cnt_field = 14'(cnt - 1);
        send_word({cpd_pkg::PKT_TYPE3, cnt_field, op, 8'($urandom)}, eos && sent == 0);
        for (int i = 1; i <= sent; i++)
            send_word($urandom, eos && i == sent);
    endtask

    task automatic write_nop(input logic v);
        cmd_valid = 1'b0;
        while (sb.pending_records.size() != 0)
            @(negedge clk);
        // words that emit nothing may still be in flight
        repeat (10) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.allow_nop = v;
    endtask

    task automatic random_unit();
        int          pick;
        int          cnt;
        int          sent;
        logic [7:0]  op;
        logic [31:0] w;
        logic        eos;
        if (sb.halted)
        begin
            // stream is dead until its end marker
            send_word($urandom, 1'($urandom_range(1)));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            w = $urandom;
            w[31:30] = 2'($urandom_range(2));
            send_word(w, $urandom_range(7) == 0);
        end
        else if (pick < 9)
        begin
            send_word(cpd_pkg::TYPE2_NOP, $urandom_range(15) == 0);
        end
        else
        begin
            case ($urandom_range(9))
                0: op = cpd_pkg::OP_INDEX_BASE;
                1: op = cpd_pkg::OP_DRAW_INDEX;
                2: op = cpd_pkg::OP_DRAW_AUTO;
                3: op = cpd_pkg::OP_WRITE_DATA;
                4: op = cpd_pkg::OP_WAIT;
                5: op = cpd_pkg::OP_EVENT;
                6: op = cpd_pkg::OP_RELEASE;
                7: op = cpd_pkg::OP_SET_CONTEXT;
                8: op = cpd_pkg::OP_SET_SH;
                default: op = cpd_pkg::OP_SET_UCONFIG;
            endcase
            if ($urandom_range(9) == 0)
                op = 8'($urandom);
            cnt  = ($urandom_range(19) == 0) ? $urandom_range(48, 7) : $urandom_range(6, 1);
            sent = cnt;
            eos  = ($urandom_range(9) == 0);
            if ($urandom_range(11) == 0)
            begin
                sent = $urandom_range(cnt - 1);
                eos  = 1'b1;
            end
            send_packet(op, cnt, sent, eos);
        end
    endtask

    initial
    begin
        int start_words;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        cmd_valid      = 1'b0;
        cmd            = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sb = new();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_nop(1'b0);
        send_word(32'h0000_0000, 1'b0);                   // bad type at offset 0
        send_word(32'hFFFF_FFFF, 1'b1);                   // ignored after the error
        send_packet(cpd_pkg::OP_SET_CONTEXT, 3, 2, 1'b1); // value record, then truncation
        send_packet(cpd_pkg::OP_DRAW_AUTO, 3, 3, 1'b0);   // spare payload word
        send_packet(cpd_pkg::OP_WAIT, 1, 1, 1'b0);
        send_packet(8'h00, 2, 1, 1'b1);                   // truncation beats unknown opcode
        send_packet(8'hFF, 1, 1, 1'b0);                   // unknown opcode at last word
        send_word(cpd_pkg::TYPE2_NOP, 1'b1);
        send_word(cpd_pkg::TYPE2_NOP, 1'b0);              // filler not allowed yet
        send_word(32'h4000_0000, 1'b1);
        send_packet(cpd_pkg::OP_WRITE_DATA, 4, 4, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);                   // header truncated on itself

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            write_nop(ph[0] ? 1'b0 : 1'b1);
            start_words = sb.live_words;
            while (sb.live_words - start_words < 306)
                random_unit();
        end

        cmd_valid = 1'b0;
        while (sb.pending_records.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending_records.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/cpd_pkg.sv
sv/cpd_decode.sv
sv/cpd_rec_fifo.sv
sv/command_packet_decoder_top.sv
verif/tb_command_packet_decoder_top.sv
